>>> rtl/linear_probe_hash_table_macros.svh
// assertion macros for the linear probing hash table checker
// expects signals clk and rst_n in the scope of each use
`ifndef LINEAR_PROBE_HASH_TABLE_MACROS_SVH
`define LINEAR_PROBE_HASH_TABLE_MACROS_SVH

// same-cycle implication, disabled during reset
`define LPHT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define LPHT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/lpht_pkg.sv
// shared types, field widths, command and status codes of the hash table
// no dependencies
package lpht_pkg;

  localparam int DEF_TABLE_SIZE = 16;

  localparam int CMD_W    = 2;
  localparam int PHONE_W  = 34;
  localparam int NAME_W   = 64;
  localparam int STATUS_W = 2;
  localparam int SLOT_W   = 4;
  localparam int PROBE_W  = 5;
  localparam int ENTRY_W  = PHONE_W + NAME_W;

  // 3*phone+5 needs two bits more than the phone number
  localparam int HASH_W      = PHONE_W + 2;
  localparam int HASH_DIGITS = HASH_W / 2;
  localparam int HASH_OFS    = 5;

  localparam logic [CMD_W-1:0] CMD_INSERT      = 2'd0;
  localparam logic [CMD_W-1:0] CMD_INSERT_REPL = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SEARCH      = 2'd2;

  localparam logic [STATUS_W-1:0] ST_STORED = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FOUND  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_MISS   = 2'd3;

  localparam logic [PROBE_W-1:0] PROBE_MAX = '1;

  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [PHONE_W-1:0] phone;
    logic [NAME_W-1:0]  name_key;
  } in_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot;
    logic [PROBE_W-1:0]  probe_count;
  } out_t;

  typedef struct packed {
    logic [PHONE_W-1:0] phone;
    logic [NAME_W-1:0]  name;
  } entry_t;

  // 3*phone + 5 by shift and add
  function automatic logic [HASH_W-1:0] make_hash_arg(input logic [PHONE_W-1:0] phone);
    logic [HASH_W-1:0] p;
    p = HASH_W'(phone);
    return (p << 1) + p + HASH_W'(HASH_OFS);
  endfunction

endpackage

>>> rtl/linear_probe_hash_table.sv
// linear probing hash table of phone/name entries, top level and sequencer
// depends on lpht_pkg, lpht_hash, lpht_ram
//
//   channel  | ports                          | payload
//   ---------+--------------------------------+------------------------------
//   input    | in_valid, in_stall, in_data    | cmd, phone, name_key
//   result   | out_valid, out_stall, out_data | status, slot, probe_count
//
// one transaction at a time: the hash takes two bits a cycle of 3*phone+5, then dispatches
// insert scans one slot a cycle, up to TABLE_SIZE; with replace, an occupied home entry is
// read and rehashed; if not at its own home it moves to a free slot by a scan; search checks
// and compares up to TABLE_SIZE probes, ending on a miss; then the output register is loaded
// reset clears the valid bits and the occupancy count
// a new transaction is taken while a result waits on out_stall
module linear_probe_hash_table #(
  parameter int TABLE_SIZE = lpht_pkg::DEF_TABLE_SIZE
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  lpht_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output lpht_pkg::out_t out_data
);
  import lpht_pkg::*;

  localparam int IW = $clog2(TABLE_SIZE);
  localparam int OW = IW + 1;
  localparam logic [OW-1:0] FULL_COUNT = OW'(TABLE_SIZE);
  localparam logic [IW-1:0] LAST_SLOT  = IW'(TABLE_SIZE - 1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_HASH,        // waiting for the home slot of the new item
    S_SCAN,        // looking for the first free slot for the new item
    S_REPL_RD,     // home entry read out, hashing its phone
    S_REPL_HASH,   // waiting for the home slot of the resident entry
    S_REPL_SCAN,   // looking for a free slot for the displaced entry
    S_SRCH_CHK,    // probe slot valid check, ram read issued
    S_SRCH_CMP,    // compare probed entry
    S_REPLY        // hand result to the output register
  } state_t;

  state_t state_r, state_nxt;

  // control
  logic [TABLE_SIZE-1:0] valid_r, valid_nxt;
  logic [OW-1:0]         occ_r, occ_nxt;
  logic                  out_valid_r, out_valid_nxt;
  out_t                  out_data_r, out_data_nxt;

  // working registers of the current transaction
  logic [CMD_W-1:0]    cmd_r, cmd_nxt;
  logic [PHONE_W-1:0]  phone_r, phone_nxt;
  logic [NAME_W-1:0]   name_r, name_nxt;
  logic [IW-1:0]       home_r, home_nxt;
  logic [IW-1:0]       cur_r, cur_nxt;
  logic [OW-1:0]       round_r, round_nxt;
  logic [PROBE_W-1:0]  probes_r, probes_nxt;
  logic [STATUS_W-1:0] status_r, status_nxt;
  logic [IW-1:0]       slot_r, slot_nxt;
  entry_t              old_r, old_nxt;

  // hash unit and ram hookup
  logic              hash_start, hash_done;
  logic [HASH_W-1:0] hash_arg;
  logic [IW-1:0]     hash_home;
  logic              ram_we;
  logic [IW-1:0]     ram_waddr, ram_raddr;
  entry_t            ram_wdata, rd_entry;
  logic [ENTRY_W-1:0] ram_rdata;
  entry_t            new_entry;
  logic [IW-1:0]     cur_next;

  lpht_hash #(.TABLE_SIZE(TABLE_SIZE)) u_hash (
    .clk   (clk),
    .rst_n (rst_n),
    .start (hash_start),
    .arg   (hash_arg),
    .done  (hash_done),
    .home  (hash_home)
  );

  lpht_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_SIZE)) u_entries (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_entry  = entry_t'(ram_rdata);
  assign new_entry = '{phone: phone_r, name: name_r};
  // wrap around at the end of the table
  assign cur_next  = (cur_r == LAST_SLOT) ? '0 : cur_r + IW'(1);

  always_comb begin
    state_nxt     = state_r;
    valid_nxt     = valid_r;
    occ_nxt       = occ_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    cmd_nxt       = cmd_r;
    phone_nxt     = phone_r;
    name_nxt      = name_r;
    home_nxt      = home_r;
    cur_nxt       = cur_r;
    round_nxt     = round_r;
    probes_nxt    = probes_r;
    status_nxt    = status_r;
    slot_nxt      = slot_r;
    old_nxt       = old_r;
    hash_start    = 1'b0;
    hash_arg      = make_hash_arg(in_data.phone);
    ram_we        = 1'b0;
    ram_waddr     = cur_r;
    ram_wdata     = new_entry;
    ram_raddr     = cur_r;

    // result taken downstream
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt    = in_data.cmd;
          phone_nxt  = in_data.phone;
          name_nxt   = in_data.name_key;
          hash_start = 1'b1;
          state_nxt  = S_HASH;
        end
      end

      S_HASH: begin
        // read the home entry in case replacement needs it
        ram_raddr = hash_home;
        if (hash_done) begin
          home_nxt   = hash_home;
          cur_nxt    = hash_home;
          round_nxt  = '0;
          probes_nxt = '0;
          slot_nxt   = '0;
          case (cmd_r)
            CMD_INSERT, CMD_INSERT_REPL: begin
              if (occ_r == FULL_COUNT) begin
                status_nxt = ST_FULL;
                state_nxt  = S_REPLY;
              end else if (cmd_r == CMD_INSERT_REPL && valid_r[hash_home]) begin
                state_nxt = S_REPL_RD;
              end else begin
                state_nxt = S_SCAN;
              end
            end
            CMD_SEARCH: begin
              state_nxt = S_SRCH_CHK;
            end
            default: begin
              // unused command: no change, report a miss
              status_nxt = ST_MISS;
              state_nxt  = S_REPLY;
            end
          endcase
        end
      end

      S_SCAN: begin
        if (!valid_r[cur_r]) begin
          ram_we           = 1'b1;
          valid_nxt[cur_r] = 1'b1;
          occ_nxt          = occ_r + OW'(1);
          status_nxt       = ST_STORED;
          slot_nxt         = cur_r;
          state_nxt        = S_REPLY;
        end else begin
          cur_nxt = cur_next;
        end
      end

      S_REPL_RD: begin
        old_nxt    = rd_entry;
        hash_arg   = make_hash_arg(rd_entry.phone);
        hash_start = 1'b1;
        state_nxt  = S_REPL_HASH;
      end

      S_REPL_HASH: begin
        if (hash_done) begin
          if (hash_home == home_r) begin
            // resident is at its own home: plain insert from home
            state_nxt = S_SCAN;
          end else begin
            // new item takes the home slot, resident moves on
            ram_we    = 1'b1;
            ram_waddr = home_r;
            slot_nxt  = home_r;
            cur_nxt   = cur_next;
            state_nxt = S_REPL_SCAN;
          end
        end
      end

      S_REPL_SCAN: begin
        if (!valid_r[cur_r]) begin
          ram_we           = 1'b1;
          ram_wdata        = old_r;
          valid_nxt[cur_r] = 1'b1;
          occ_nxt          = occ_r + OW'(1);
          status_nxt       = ST_STORED;
          state_nxt        = S_REPLY;
        end else begin
          cur_nxt = cur_next;
        end
      end

      S_SRCH_CHK: begin
        if (round_r == FULL_COUNT || !valid_r[cur_r]) begin
          status_nxt = ST_MISS;
          slot_nxt   = '0;
          state_nxt  = S_REPLY;
        end else begin
          state_nxt = S_SRCH_CMP;
        end
      end

      S_SRCH_CMP: begin
        if (probes_r != PROBE_MAX) begin
          probes_nxt = probes_r + PROBE_W'(1);
        end
        if (rd_entry == new_entry) begin
          status_nxt = ST_FOUND;
          slot_nxt   = cur_r;
          state_nxt  = S_REPLY;
        end else begin
          cur_nxt   = cur_next;
          round_nxt = round_r + OW'(1);
          state_nxt = S_SRCH_CHK;
        end
      end

      S_REPLY: begin
        // wait while the previous result is still stalled
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.status      = status_r;
          out_data_nxt.slot        = SLOT_W'(slot_r);
          out_data_nxt.probe_count = probes_r;
          state_nxt                = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state, occupancy and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      valid_r     <= '0;
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      occ_r       <= occ_nxt;
      out_valid_r <= out_valid_nxt;
      out_data_r  <= out_data_nxt;
    end
  end

  // transaction working registers, no reset needed
  always_ff @(posedge clk) begin
    cmd_r    <= cmd_nxt;
    phone_r  <= phone_nxt;
    name_r   <= name_nxt;
    home_r   <= home_nxt;
    cur_r    <= cur_nxt;
    round_r  <= round_nxt;
    probes_r <= probes_nxt;
    status_r <= status_nxt;
    slot_r   <= slot_nxt;
    old_r    <= old_nxt;
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> rtl/lpht_ram.sv
// generic single write port ram with registered read
// no dependencies
module lpht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/lpht_hash.sv
// iterative home slot unit: (3*phone+5) mod table size, two bits per cycle
// depends on lpht_pkg
module lpht_hash #(
  parameter int TABLE_SIZE = lpht_pkg::DEF_TABLE_SIZE,
  localparam int IW = $clog2(TABLE_SIZE)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [lpht_pkg::HASH_W-1:0] arg,
  output logic                        done,
  output logic [IW-1:0]               home
);
  import lpht_pkg::*;

  localparam int RW = IW + 2;
  localparam int CW = $clog2(HASH_DIGITS + 1);
  localparam logic [RW-1:0] MOD1 = RW'(TABLE_SIZE);
  localparam logic [RW-1:0] MOD2 = RW'(2 * TABLE_SIZE);
  localparam logic [RW-1:0] MOD3 = RW'(3 * TABLE_SIZE);

  logic [HASH_W-1:0] arg_r;
  logic [IW-1:0]     rem_r, rem_nxt;
  logic [CW-1:0]     cnt_r;
  logic              busy_r, done_r;
  logic [RW-1:0]     part;

  // remainder stays below the modulus, so 4*rem+digit is below four times it
  always_comb begin
    part = {rem_r, arg_r[HASH_W-1 -: 2]};
    if (part >= MOD3) begin
      rem_nxt = IW'(part - MOD3);
    end else if (part >= MOD2) begin
      rem_nxt = IW'(part - MOD2);
    end else if (part >= MOD1) begin
      rem_nxt = IW'(part - MOD1);
    end else begin
      rem_nxt = IW'(part);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(HASH_DIGITS);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      arg_r <= arg;
      rem_r <= '0;
    end else if (busy_r) begin
      arg_r <= arg_r << 2;
      rem_r <= rem_nxt;
    end
  end

  assign done = done_r;
  assign home = rem_r;

endmodule

>>> rtl/lpht_checker.sv
// port-level checks of the hash table, bound to the top level
// depends on lpht_pkg and linear_probe_hash_table_macros.svh
`include "linear_probe_hash_table_macros.svh"

module lpht_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           in_valid,
  input logic           in_stall,
  input lpht_pkg::in_t  in_data,
  input logic           out_valid,
  input logic           out_stall,
  input lpht_pkg::out_t out_data
);
  import lpht_pkg::*;

  // a stalled result holds
  `LPHT_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "result changed under stall")

  // one transaction at a time: busy right after an accept
  `LPHT_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "accepted two transactions in a row")

  // full table reports slot and probe count zero
  `LPHT_ASSERT_NOW(a_full_zero, out_valid && out_data.status == ST_FULL, out_data.slot == '0 && out_data.probe_count == '0, "full result not zeroed")

  // inserts never count probes
  `LPHT_ASSERT_NOW(a_store_no_probe, out_valid && out_data.status == ST_STORED, out_data.probe_count == '0, "store reported probes")

  // a hit needs at least one comparison
  `LPHT_ASSERT_NOW(a_found_probed, out_valid && out_data.status == ST_FOUND, out_data.probe_count != '0, "hit without comparison")

endmodule

bind linear_probe_hash_table lpht_checker u_lpht_checker (.*);
